// File: hw/rtl/ncsc_pkg.sv
// Shared types and constants for the nearest color sample classifier.
// Used by the channel interfaces and the classifier top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncsc_pkg;

  // Field widths of one input beat and one result beat.
  localparam int unsigned OP_W            = 1;
  localparam int unsigned COLOR_W         = 8;
  localparam int unsigned RAND_W          = 16;
  localparam int unsigned SAMPLE_COUNT_W  = 7;

  // Configuration register widths and reset values.
  localparam int unsigned WEIGHT_W        = 8;
  localparam int unsigned RAMP_W          = 10;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned CFG_DATA_W      = 10;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(16);
  localparam logic [RAMP_W-1:0]   RAMP_RESET = RAMP_W'(50);

  // Default sample table depth.
  localparam int unsigned MAX_SAMPLES_DEF = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD      = 1'b0;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_HUE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SATURATION = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_VALUE      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LENGTH       = 2'd3;

  // One stored HSV sample.
  typedef struct packed {
    logic [COLOR_W-1:0] hue;
    logic [COLOR_W-1:0] saturation;
    logic [COLOR_W-1:0] value;
  } sample_t;

endpackage

`default_nettype wire

// File: hw/rtl/ncsc_if.sv
// Valid/ready channel interfaces for the classifier input and result beats.
// Depends on ncsc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one add or classify request per beat.
interface ncsc_item_if;
  logic                                valid;
  logic                                ready;
  logic [ncsc_pkg::OP_W-1:0]           operation;
  logic [ncsc_pkg::COLOR_W-1:0]        pixel_hue;
  logic [ncsc_pkg::COLOR_W-1:0]        pixel_saturation;
  logic [ncsc_pkg::COLOR_W-1:0]        pixel_value;
  logic [ncsc_pkg::RAND_W-1:0]         random_fraction;

  modport source (
    output valid, operation, pixel_hue, pixel_saturation, pixel_value, random_fraction,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_hue, pixel_saturation, pixel_value, random_fraction,
    output ready
  );
endinterface

// Result channel: one beat per accepted input beat.
interface ncsc_result_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  selected;
  logic                                  sample_accepted;
  logic [ncsc_pkg::SAMPLE_COUNT_W-1:0]   sample_count;

  modport source (
    output valid, selected, sample_accepted, sample_count,
    input  ready
  );
  modport sink (
    input  valid, selected, sample_accepted, sample_count,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/nearest_color_sample_classifier.sv
// Nearest color sample classifier: learned HSV sample table in one memory.
// Depends on ncsc_pkg and the channel interfaces in ncsc_if.sv.
//
// Usage:
//   The item channel carries add and classify beats. An add stores its HSV
//   triple in the next free table slot, or drops it when the table is full.
//   A classify walks the stored samples, takes the smallest weighted L1
//   distance d (Q4.4 weights, integer part) and selects the pixel when
//   d < ramp_length and (ramp_length - d) / ramp_length beats the random
//   fraction. Every item returns exactly one beat on the result channel.
//   Configuration registers are written through write_enable, write_index
//   and write_data; the user must write them only while the block is idle,
//   since the block itself does not enforce it.
//   An add moves to the finish state, which loads its result once the output
//   register is free. A classify scans the stored samples: the single read port
//   of the sample memory delivers one sample per cycle, followed by the
//   distance pipeline and the ramp test; an empty table skips the scan. One item
//   is in work at a time and the next one is taken in the cycle after a result loads.
// Reset and stalls:
//   Reset empties the table, restores the weights to 1.0 and the ramp
//   length to 50. A finished result waits in the output register while the
//   receiver stalls; the next item is still accepted and processed, and its
//   result holds in the block until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module nearest_color_sample_classifier #(
  parameter int unsigned MAX_SAMPLES = ncsc_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              write_enable,
  input  wire logic [ncsc_pkg::CFG_INDEX_W-1:0]  write_index,
  input  wire logic [ncsc_pkg::CFG_DATA_W-1:0]   write_data,
  ncsc_item_if.sink                              item,
  ncsc_result_if.source                          result
);
  import ncsc_pkg::*;

  localparam int unsigned ADDR_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CNT_EXT_W = (CNT_W > SAMPLE_COUNT_W) ? CNT_W : SAMPLE_COUNT_W;
  localparam int unsigned PROD_W    = WEIGHT_W + COLOR_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned DIST_W    = SUM_W - 4;
  localparam int unsigned RHS_W     = RAND_W + RAMP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RAMP,
    S_TEST,
    S_FINISH
  } state_t;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  state_t state;

  // Configuration registers.
  logic [WEIGHT_W-1:0] weight_hue;
  logic [WEIGHT_W-1:0] weight_saturation;
  logic [WEIGHT_W-1:0] weight_value;
  logic [RAMP_W-1:0]   ramp_length;

  // Table fill and scan control.
  logic [CNT_W-1:0]    stored_count;
  logic [ADDR_W-1:0]   scan_idx;
  logic                rd_en;
  logic                rd_v;
  logic                p_v;
  logic                table_full;
  logic                accept;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;

  // Latched pixel of the item in work.
  sample_t             pixel;
  logic [RAND_W-1:0]   pixel_rand;

  // Distance pipeline.
  sample_t             rd_data;
  logic [PROD_W-1:0]   prod_hue;
  logic [PROD_W-1:0]   prod_saturation;
  logic [PROD_W-1:0]   prod_value;
  logic [SUM_W-1:0]    dist_sum;
  logic [DIST_W-1:0]   sample_dist;
  logic [RAMP_W-1:0]   best;

  // Ramp test.
  logic                ramp_hit;
  logic [RAMP_W-1:0]   ramp_span;
  logic [RHS_W-1:0]    ramp_rhs;

  // Pending result of the item in work and the output register.
  logic                pend_selected;
  logic                pend_accepted;
  logic [CNT_W-1:0]    pend_count;
  logic [CNT_EXT_W-1:0] pend_count_ext;
  logic                res_valid;
  logic                res_selected;
  logic                res_accepted;
  logic [SAMPLE_COUNT_W-1:0] res_count;

  sample_t             sample_in;

  // Sample memory: one write port for adds, one registered read port for scans.
  sample_t mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_idx];
    end
  end

  // Handshake and memory control.
  assign item.ready  = (state == S_IDLE);
  assign accept      = item.valid && (state == S_IDLE);
  assign table_full  = (stored_count >= CNT_W'(MAX_SAMPLES));
  assign wr_en       = accept && (item.operation == OP_ADD) && !table_full;
  assign wr_addr     = stored_count[ADDR_W-1:0];
  assign rd_en       = (state == S_SCAN);
  assign sample_in   = '{hue: item.pixel_hue, saturation: item.pixel_saturation,
                         value: item.pixel_value};

  // Weighted L1 distance of the sample in the product stage, integer part.
  assign dist_sum    = SUM_W'(prod_hue) + SUM_W'(prod_saturation) + SUM_W'(prod_value);
  assign sample_dist = dist_sum[SUM_W-1:4];

  assign pend_count_ext = CNT_EXT_W'(pend_count);

  assign result.valid           = res_valid;
  assign result.selected        = res_selected;
  assign result.sample_accepted = res_accepted;
  assign result.sample_count    = res_count;

  // Control state, datapath pipeline and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      weight_hue        <= WEIGHT_ONE;
      weight_saturation <= WEIGHT_ONE;
      weight_value      <= WEIGHT_ONE;
      ramp_length       <= RAMP_RESET;
      stored_count      <= '0;
      rd_v              <= 1'b0;
      p_v               <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      // Configuration writes.
      if (write_enable) begin
        unique case (write_index)
          REG_WEIGHT_HUE:        weight_hue        <= write_data[WEIGHT_W-1:0];
          REG_WEIGHT_SATURATION: weight_saturation <= write_data[WEIGHT_W-1:0];
          REG_WEIGHT_VALUE:      weight_value      <= write_data[WEIGHT_W-1:0];
          REG_RAMP_LENGTH:       ramp_length       <= write_data[RAMP_W-1:0];
          default: ;
        endcase
      end

      // The output beat leaves when the receiver takes it; the finish state
      // reloads the register itself.
      if (res_valid && result.ready && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end

      // Product stage: one weighted byte difference per channel.
      rd_v <= rd_en;
      p_v  <= rd_v;
      if (rd_v) begin
        prod_hue        <= PROD_W'(weight_hue) * PROD_W'(abs_diff(pixel.hue, rd_data.hue));
        prod_saturation <= PROD_W'(weight_saturation) *
                           PROD_W'(abs_diff(pixel.saturation, rd_data.saturation));
        prod_value      <= PROD_W'(weight_value) *
                           PROD_W'(abs_diff(pixel.value, rd_data.value));
      end

      // Running minimum; it never exceeds the ramp length it starts from.
      if (p_v && (sample_dist < DIST_W'(best))) begin
        best <= sample_dist[RAMP_W-1:0];
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            pixel         <= sample_in;
            pixel_rand    <= item.random_fraction;
            pend_selected <= 1'b0;
            if (item.operation == OP_ADD) begin
              if (!table_full) begin
                stored_count  <= stored_count + 1'b1;
                pend_accepted <= 1'b1;
                pend_count    <= stored_count + 1'b1;
              end else begin
                pend_accepted <= 1'b0;
                pend_count    <= stored_count;
              end
              state <= S_FINISH;
            end else begin
              pend_accepted <= 1'b0;
              pend_count    <= stored_count;
              best          <= ramp_length;
              scan_idx      <= '0;
              state         <= (stored_count == '0) ? S_RAMP : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // One memory read per cycle up to the last stored sample.
          scan_idx <= scan_idx + 1'b1;
          if ((CNT_W'(scan_idx) + 1'b1) == stored_count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !p_v) begin
            state <= S_RAMP;
          end
        end
        S_RAMP: begin
          ramp_hit  <= (best < ramp_length);
          ramp_span <= ramp_length - best;
          ramp_rhs  <= RHS_W'(pixel_rand) * RHS_W'(ramp_length);
          state     <= S_TEST;
        end
        S_TEST: begin
          // (N - d) * 65536 > r * N
          pend_selected <= ramp_hit && ({ramp_span, {RAND_W{1'b0}}} > ramp_rhs);
          state         <= S_FINISH;
        end
        S_FINISH: begin
          if (!res_valid || result.ready) begin
            res_valid    <= 1'b1;
            res_selected <= pend_selected;
            res_accepted <= pend_accepted;
            res_count    <= pend_count_ext[SAMPLE_COUNT_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The table never holds more samples than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count exceeds table depth");

  // An add on a full table leaves the count alone.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (item.operation == OP_ADD) && table_full |=> $stable(stored_count))
    else $error("add on a full table changed the count");

  // The distance pipeline is empty whenever a new item can enter.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_v && !p_v))
    else $error("distance pipeline busy while idle");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the nearest color sample classifier.
// It drives add and classify beats, predicts each result in its own model, and checks every beat.
// Depends on ncsc_pkg, the channel interfaces and the classifier RTL.
`timescale 1ns / 1ps

module tb_top;
  import ncsc_pkg::*;

  localparam int unsigned TABLE_DEPTH  = MAX_SAMPLES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PRINT_CAP    = 100;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned FINAL_WAIT   = 80;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COLOR_W-1:0] hue;
    logic [COLOR_W-1:0] sat;
    logic [COLOR_W-1:0] val;
    logic [RAND_W-1:0]  frac;
  } request_t;

  typedef struct packed {
    logic                      selected;
    logic                      accepted;
    logic [SAMPLE_COUNT_W-1:0] count;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0]  write_data;

  ncsc_item_if   item_ch ();
  ncsc_result_if result_ch ();

  nearest_color_sample_classifier uut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .item         (item_ch),
    .result       (result_ch)
  );

  // Settings per random phase; the last two phases draw theirs at random.
  int unsigned phase_wh   [PHASES] = '{16, 0, 255, 255, 8, 0, 0, 0};
  int unsigned phase_ws   [PHASES] = '{16, 0, 255, 0, 32, 255, 0, 0};
  int unsigned phase_wv   [PHASES] = '{16, 0, 255, 0, 4, 0, 0, 0};
  int unsigned phase_ramp [PHASES] = '{50, 1, 1023, 1, 200, 1023, 0, 0};

  // Shadow of the block: learned table, fill level and registers.
  sample_t             model_table [TABLE_DEPTH];
  int unsigned         model_count = 0;
  logic [WEIGHT_W-1:0] model_w_hue;
  logic [WEIGHT_W-1:0] model_w_sat;
  logic [WEIGHT_W-1:0] model_w_val;
  logic [RAMP_W-1:0]   model_ramp;

  request_t    pending_requests [$];
  outcome_t    predicted_results [$];
  sample_t     learned_colors [$];
  request_t    on_bus;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          idling_on;
  int unsigned send_gap;
  int unsigned recv_stall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned color_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // Applies one beat to the shadow state and returns the result it must produce.
  function automatic outcome_t predict_outcome(request_t req);
    outcome_t        res;
    int unsigned     best;
    int unsigned     q;
    int unsigned     sample_dist;
    longint unsigned lhs;
    longint unsigned rhs;
    res = '0;
    if (req.op == OP_ADD) begin
      if (model_count < TABLE_DEPTH) begin
        model_table[model_count] = '{hue: req.hue, saturation: req.sat, value: req.val};
        model_count++;
        res.accepted = 1'b1;
      end
    end else begin
      best = model_ramp;
      for (int unsigned i = 0; i < model_count; i++) begin
        q = model_w_hue * color_gap(req.hue, model_table[i].hue)
          + model_w_sat * color_gap(req.sat, model_table[i].saturation)
          + model_w_val * color_gap(req.val, model_table[i].value);
        sample_dist = q >> 4;
        if (sample_dist < best) best = sample_dist;
      end
      // Linear ramp: closer colors win against a larger share of the random range.
      if (best < model_ramp) begin
        lhs = model_ramp - best;
        lhs = lhs << 16;
        rhs = req.frac;
        rhs = rhs * model_ramp;
        res.selected = (lhs > rhs);
      end
    end
    res.count = model_count[SAMPLE_COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (errors < PRINT_CAP)
      $display("ERROR at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Item driver: holds a beat until it is taken, with random gaps between beats.
  always @(posedge clk) begin : drive_items
    request_t nxt;
    if (rst) begin
      item_ch.valid            <= 1'b0;
      item_ch.operation        <= OP_ADD;
      item_ch.pixel_hue        <= '0;
      item_ch.pixel_saturation <= '0;
      item_ch.pixel_value      <= '0;
      item_ch.random_fraction  <= '0;
      on_bus                   = '0;
      send_gap                 <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready)
        predicted_results = {predicted_results, predict_outcome(on_bus)};
      if (item_ch.valid && !item_ch.ready) begin
        // Beat still waiting for the block.
      end else if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        item_ch.valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        item_ch.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        send_gap      <= $urandom_range(1, 7) - 1;
        item_ch.valid <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        on_bus                   = nxt;
        item_ch.valid            <= 1'b1;
        item_ch.operation        <= nxt.op;
        item_ch.pixel_hue        <= nxt.hue;
        item_ch.pixel_saturation <= nxt.sat;
        item_ch.pixel_value      <= nxt.val;
        item_ch.random_fraction  <= nxt.frac;
      end
    end
  end

  // Result monitor: compares each beat with the oldest prediction, with random stalls.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall      <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result beat, count", result_ch.sample_count, 0);
        end else begin
          want = predicted_results.pop_front();
          if (result_ch.selected !== want.selected)
            report_mismatch("selected", result_ch.selected, want.selected);
          if (result_ch.sample_accepted !== want.accepted)
            report_mismatch("sample_accepted", result_ch.sample_accepted, want.accepted);
          if (result_ch.sample_count !== want.count)
            report_mismatch("sample_count", result_ch.sample_count, want.count);
        end
      end
      if (recv_stall != 0) begin
        recv_stall      <= recv_stall - 1;
        result_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        recv_stall      <= $urandom_range(1, 7) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nearest_color_sample_classifier: mismatch");
      $finish;
    end
  end

  task automatic queue_request(logic [OP_W-1:0] op, int unsigned h, int unsigned s,
                               int unsigned v, int unsigned frac);
    request_t req;
    sample_t  color;
    req = '{op: op, hue: h[COLOR_W-1:0], sat: s[COLOR_W-1:0],
            val: v[COLOR_W-1:0], frac: frac[RAND_W-1:0]};
    pending_requests = {pending_requests, req};
    if (op == OP_ADD && learned_colors.size() < TABLE_DEPTH) begin
      color = '{hue: h[COLOR_W-1:0], saturation: s[COLOR_W-1:0], value: v[COLOR_W-1:0]};
      learned_colors = {learned_colors, color};
    end
  endtask

  // Waits until every beat is sent and every result is back, then a short settle.
  task automatic drain_all();
    @(negedge clk);
    while (pending_requests.size() != 0 || predicted_results.size() != 0 || item_ch.valid)
      @(negedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data[CFG_DATA_W-1:0];
    case (idx)
      REG_WEIGHT_HUE:        model_w_hue = data[WEIGHT_W-1:0];
      REG_WEIGHT_SATURATION: model_w_sat = data[WEIGHT_W-1:0];
      REG_WEIGHT_VALUE:      model_w_val = data[WEIGHT_W-1:0];
      default:               model_ramp  = data[RAMP_W-1:0];
    endcase
  endtask

  task automatic apply_settings(int unsigned wh, int unsigned ws, int unsigned wv,
                                int unsigned ramp);
    write_reg(REG_WEIGHT_HUE, wh);
    write_reg(REG_WEIGHT_SATURATION, ws);
    write_reg(REG_WEIGHT_VALUE, wv);
    write_reg(REG_RAMP_LENGTH, ramp);
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  function automatic int unsigned nudge(logic [COLOR_W-1:0] base, int unsigned spread);
    int c;
    c = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c;
  endfunction

  // Mostly pixels near a learned color, so distances land around the ramp.
  task automatic queue_random_request();
    sample_t     base;
    int unsigned spread;
    int unsigned frac;
    bit          near;
    near = (learned_colors.size() != 0) && ($urandom_range(0, 9) < 7);
    if (near) base = learned_colors[$urandom_range(0, learned_colors.size() - 1)];
    else base = '{hue: COLOR_W'($urandom_range(0, 255)),
                  saturation: COLOR_W'($urandom_range(0, 255)),
                  value: COLOR_W'($urandom_range(0, 255))};
    case ($urandom_range(0, 3))
      0:       spread = 0;
      1:       spread = 2;
      2:       spread = 12;
      default: spread = 60;
    endcase
    case ($urandom_range(0, 9))
      0:       frac = 0;
      1:       frac = 65535;
      default: frac = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 7) == 0)
      queue_request(OP_ADD, nudge(base.hue, 60), nudge(base.saturation, 60),
                    nudge(base.value, 60), $urandom_range(0, 65535));
    else
      queue_request(OP_CLASSIFY, nudge(base.hue, spread), nudge(base.saturation, spread),
                    nudge(base.value, spread), frac);
  endtask

  initial begin : stimulus
    rst                        = 1'b1;
    write_enable               = 1'b0;
    write_index                = REG_WEIGHT_HUE;
    write_data                 = '0;
    idling_on                  = 1'b1;
    model_w_hue                = WEIGHT_ONE;
    model_w_sat                = WEIGHT_ONE;
    model_w_val                = WEIGHT_ONE;
    model_ramp                 = RAMP_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at reset settings: empty table first, then exact and edge distances.
    @(negedge clk);
    queue_request(OP_CLASSIFY, 0, 0, 0, 0);
    queue_request(OP_CLASSIFY, 255, 255, 255, 65535);
    queue_request(OP_ADD, 0, 0, 0, 0);
    queue_request(OP_ADD, 255, 255, 255, 65535);
    queue_request(OP_ADD, 128, 64, 200, 0);
    queue_request(OP_CLASSIFY, 0, 0, 0, 0);
    queue_request(OP_CLASSIFY, 255, 255, 255, 65535);
    queue_request(OP_CLASSIFY, 128, 64, 200, 65535);
    queue_request(OP_CLASSIFY, 10, 10, 10, 32768);
    queue_request(OP_CLASSIFY, 5, 5, 5, 0);
    queue_request(OP_CLASSIFY, 128, 128, 128, 0);
    // Distance one below the ramp, then exactly on it.
    queue_request(OP_CLASSIFY, 128, 64, 249, 0);
    queue_request(OP_CLASSIFY, 128, 64, 250, 0);
    queue_request(OP_CLASSIFY, 170, 85, 170, 43690);
    queue_request(OP_CLASSIFY, 85, 170, 85, 21845);
    drain_all();

    // A zero-length ramp selects nothing, not even an exact match.
    apply_settings(16, 16, 16, 0);
    @(negedge clk);
    queue_request(OP_CLASSIFY, 0, 0, 0, 0);
    queue_request(OP_CLASSIFY, 255, 255, 255, 0);
    drain_all();

    // Random phases, each with its own register settings; the table fills up on the way.
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2)
        apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(1, 1023));
      else
        apply_settings(phase_wh[p], phase_ws[p], phase_wv[p], phase_ramp[p]);
      idling_on = (p != 2) && (p != PHASES - 1);
      @(negedge clk);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++)
        queue_random_request();
      drain_all();
    end

    repeat (FINAL_WAIT) @(posedge clk);
    if (errors == 0)
      $display("nearest_color_sample_classifier: match");
    else
      $display("nearest_color_sample_classifier: mismatch");
    $finish;
  end

endmodule
